FILE: rtl/core/mfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame reassembler package
// Byte codes, frame layout constants and shared types of the reassembler.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFE;
  localparam logic [7:0] CMD_BYTE  = 8'h80;
  localparam logic [7:0] AREA_ID   = 8'h01;
  localparam logic [7:0] TAIL_BYTE = 8'hAA;

  // Frame position of the first fragment byte (the sync byte is position 0).
  localparam int unsigned DATA_START = 7;
  // Upstream header: sync, command, sync, area, node.
  localparam int unsigned HEAD_LEN   = 5;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_HEAD,
    EM_READ,
    EM_DATA,
    EM_SUM,
    EM_TAIL
  } emit_state_e;

  // Request from the parser to send the message of one node.
  typedef struct packed {
    logic       start;
    logic [7:0] node;
  } emit_req_t;

  function automatic logic [7:0] head_byte(input logic [2:0] idx, input logic [7:0] node);
    logic [7:0] res;
    unique case (idx)
      3'd0:    res = SYNC_BYTE;
      3'd1:    res = CMD_BYTE;
      3'd2:    res = SYNC_BYTE;
      3'd3:    res = AREA_ID;
      default: res = node;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/mfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame reassembler channels
// Valid/ready byte channels for received bytes and upstream frame bytes.
// ----------------------------------------------------------------------------
interface mfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

FILE: rtl/core/mfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 96
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame parser
// Tracks the incoming frame, writes fragment bytes straight into the node
// store and keeps the per-node fill counts.
// ----------------------------------------------------------------------------
module mfr_parser import mfr_pkg::*; #(
  parameter int unsigned NODE_COUNT            = 4,
  parameter int unsigned FRAGMENT_BYTES        = 6,
  parameter int unsigned FRAGMENTS_PER_MESSAGE = 4,
  localparam int unsigned MSG_BYTES = FRAGMENT_BYTES * FRAGMENTS_PER_MESSAGE,
  localparam int unsigned DEPTH     = NODE_COUNT * MSG_BYTES,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfr_rx_if.sink        rx_i,
  input  logic          emit_busy_i,
  output emit_req_t     emit_req_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o
);

  localparam int unsigned NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned FILL_W = $clog2(FRAGMENTS_PER_MESSAGE + 1);
  localparam logic [8:0] DATA_FIRST = 9'(DATA_START);
  localparam logic [8:0] CHECK_POS  = 9'(DATA_START + FRAGMENT_BYTES);
  localparam logic [8:0] MIN_FRAME  = 9'(DATA_START + FRAGMENT_BYTES + 1);

  logic              in_frame_q, in_frame_d;
  logic [8:0]        pos_q, pos_d;
  logic [8:0]        left_q, left_d;
  logic [8:0]        len_q, len_d;
  logic [7:0]        node_q, node_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        chk_q, chk_d;
  logic [FILL_W-1:0] fill_q [NODE_COUNT];
  logic [FILL_W-1:0] fill_d [NODE_COUNT];

  logic              accept;
  logic [8:0]        pos_inc;
  logic [8:0]        left_dec;
  logic [8:0]        ofs;
  logic              node_ok;
  logic [NODE_W-1:0] node_idx;
  logic [FILL_W-1:0] fill_inc;
  logic              in_data;

  assign rx_i.ready = !emit_busy_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign pos_inc    = pos_q + 9'd1;
  assign ofs        = pos_inc - DATA_FIRST;
  assign in_data    = (pos_inc >= DATA_FIRST) && (pos_inc < CHECK_POS);
  assign left_dec   = (left_q != 9'd0) ? left_q - 9'd1 : left_q;
  assign node_ok    = (node_d != 8'd0) && (node_d <= 8'(NODE_COUNT));
  assign node_idx   = NODE_W'(node_d - 8'd1);
  assign fill_inc   = fill_q[node_idx] + FILL_W'(1);

  // Fragment bytes go to the slot after the node's filled fragments. A frame
  // that later fails its checks leaves that slot unclaimed, so it is simply
  // overwritten by the next good frame.
  assign wdata_o = rx_i.rx_byte;
  assign waddr_o = AW'(node_idx * MSG_BYTES) + AW'(fill_q[node_idx] * FRAGMENT_BYTES)
                 + AW'(ofs);

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    left_d     = left_q;
    len_d      = len_q;
    node_d     = node_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    fill_d     = fill_q;
    we_o       = 1'b0;
    emit_req_o = '{start: 1'b0, node: node_q};
    if (accept) begin
      if (rx_i.rx_byte == SYNC_BYTE) begin
        in_frame_d = 1'b1;
        pos_d      = 9'd0;
        len_d      = 9'd0;
        left_d     = 9'd0;
        node_d     = 8'd0;
        sum_d      = 8'd0;
        chk_d      = 8'd0;
      end else if (in_frame_q) begin
        pos_d = pos_inc;
        if (pos_inc == 9'd2) begin
          len_d  = {1'b0, rx_i.rx_byte} + 9'd4;
          left_d = {1'b0, rx_i.rx_byte} + 9'd1;
        end else if (pos_inc != 9'd1) begin
          if (pos_inc == 9'd3) begin
            node_d = rx_i.rx_byte;
          end else if (in_data) begin
            sum_d = sum_q + rx_i.rx_byte;
            we_o  = node_ok;
          end else if (pos_inc == CHECK_POS) begin
            chk_d = rx_i.rx_byte;
          end
          left_d = left_dec;
          if (left_dec == 9'd0) begin
            in_frame_d = 1'b0;
            if ((len_q >= MIN_FRAME) && (chk_d == sum_q) && node_ok) begin
              if (fill_inc == FILL_W'(FRAGMENTS_PER_MESSAGE)) begin
                fill_d[node_idx] = '0;
                emit_req_o.start = 1'b1;
              end else begin
                fill_d[node_idx] = fill_inc;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      left_q     <= '0;
      len_q      <= '0;
      node_q     <= '0;
      sum_q      <= '0;
      chk_q      <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      left_q     <= left_d;
      len_q      <= len_d;
      node_q     <= node_d;
      sum_q      <= sum_d;
      chk_q      <= chk_d;
      fill_q     <= fill_d;
    end
  end

endmodule

FILE: rtl/core/mfr_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Upstream frame emitter
// Reads a node's message from the store and sends header, data, check byte
// and tail through a registered output stage.
// ----------------------------------------------------------------------------
module mfr_emitter import mfr_pkg::*; #(
  parameter int unsigned NODE_COUNT            = 4,
  parameter int unsigned FRAGMENT_BYTES        = 6,
  parameter int unsigned FRAGMENTS_PER_MESSAGE = 4,
  localparam int unsigned MSG_BYTES = FRAGMENT_BYTES * FRAGMENTS_PER_MESSAGE,
  localparam int unsigned DEPTH     = NODE_COUNT * MSG_BYTES,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  emit_req_t     emit_req_i,
  output logic          busy_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rdata_i,
  mfr_tx_if.source      tx_o
);

  localparam int unsigned CNT_MAX = (MSG_BYTES > HEAD_LEN) ? MSG_BYTES : HEAD_LEN;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX);
  localparam logic [CNT_W-1:0] HEAD_END = CNT_W'(HEAD_LEN - 1);
  localparam logic [CNT_W-1:0] DATA_END = CNT_W'(MSG_BYTES - 1);

  emit_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       node_q, node_d;
  logic [7:0]       sum_q, sum_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q, ol_d;
  logic             out_free;

  assign out_free = !ov_q || tx_o.ready;
  assign busy_o   = (state_q != EM_IDLE);
  assign raddr_o  = AW'((node_q - 8'd1) * MSG_BYTES) + AW'(cnt_q);
  assign re_o     = (state_q == EM_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EM_IDLE: if (emit_req_i.start) state_d = EM_HEAD;
      EM_HEAD: if (out_free && (cnt_q == HEAD_END)) state_d = EM_READ;
      EM_READ: state_d = EM_DATA;
      EM_DATA: begin
        if (out_free) state_d = (cnt_q == DATA_END) ? EM_SUM : EM_READ;
      end
      EM_SUM:  if (out_free) state_d = EM_TAIL;
      EM_TAIL: if (out_free) state_d = EM_IDLE;
      default: state_d = EM_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    node_d = node_q;
    sum_d  = sum_q;
    ov_d   = ov_q && !tx_o.ready;
    ob_d   = ob_q;
    ol_d   = ol_q;
    unique case (state_q)
      EM_IDLE: begin
        if (emit_req_i.start) begin
          cnt_d  = '0;
          node_d = emit_req_i.node;
          sum_d  = emit_req_i.node;
        end
      end
      EM_HEAD: begin
        if (out_free) begin
          ov_d  = 1'b1;
          ob_d  = head_byte(3'(cnt_q), node_q);
          ol_d  = 1'b0;
          cnt_d = (cnt_q == HEAD_END) ? '0 : cnt_q + CNT_W'(1);
        end
      end
      EM_READ: begin
      end
      EM_DATA: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = rdata_i;
          ol_d = 1'b0;
          // The check byte covers every data byte but the last one.
          if (cnt_q != DATA_END) begin
            sum_d = sum_q + rdata_i;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      EM_SUM: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = sum_q;
          ol_d = 1'b0;
        end
      end
      EM_TAIL: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = TAIL_BYTE;
          ol_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign tx_o.valid   = ov_q;
  assign tx_o.tx_byte = ob_q;
  assign tx_o.tx_last = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    sum_q  <= sum_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
  end

endmodule

FILE: rtl/core/mesh_frame_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame reassembler
// Collects data fragments from mesh link frames per source node and sends
// one upstream frame per node each time its message is complete.
// ----------------------------------------------------------------------------
// Received bytes arrive one beat at a time on rx_i; a beat is taken in the
// same cycle it is offered whenever no upstream frame is being read out, so
// the input runs at one byte per cycle. A 0xFE byte starts (or restarts) a
// frame; byte 2 plus four is the frame length, byte 3 the source node, and
// bytes 7 onward carry a fragment followed by its check byte. Fragment bytes
// are written directly into a single node store RAM (NODE_COUNT messages of
// FRAGMENT_BYTES * FRAGMENTS_PER_MESSAGE bytes); only the per-node fill counts
// live in flip-flops, so no clearing pass follows reset. When the last byte
// of a good frame completes a node's message, the input stalls while the
// emitter sends FE 80 FE 01 node, the message bytes, a check byte (node plus
// all message bytes but the last) and the tail AA on tx_o, with tx_last set
// on the tail beat. The store has a registered read, and each data byte is
// read in EM_READ just before EM_DATA loads it into the output register,
// and the emitter waits while tx_o applies back pressure. Reads never collide
// with writes because the parser only writes on accepted beats, and no beat
// is accepted while a frame is being read out.
// ----------------------------------------------------------------------------
module mesh_frame_reassembler import mfr_pkg::*; #(
  parameter int unsigned NODE_COUNT            = 4,
  parameter int unsigned FRAGMENT_BYTES        = 6,
  parameter int unsigned FRAGMENTS_PER_MESSAGE = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mfr_rx_if.sink   rx_i,
  mfr_tx_if.source tx_o
);

  localparam int unsigned MSG_BYTES = FRAGMENT_BYTES * FRAGMENTS_PER_MESSAGE;
  localparam int unsigned DEPTH     = NODE_COUNT * MSG_BYTES;
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  emit_req_t         emit_req;
  logic              emit_busy;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;

  // Frame parser: owns the write port of the node store.
  mfr_parser #(
    .NODE_COUNT            (NODE_COUNT),
    .FRAGMENT_BYTES        (FRAGMENT_BYTES),
    .FRAGMENTS_PER_MESSAGE (FRAGMENTS_PER_MESSAGE)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .emit_busy_i (emit_busy),
    .emit_req_o  (emit_req),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  // Node store holding the partially collected messages.
  mfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Upstream frame emitter: owns the read port of the node store.
  mfr_emitter #(
    .NODE_COUNT            (NODE_COUNT),
    .FRAGMENT_BYTES        (FRAGMENT_BYTES),
    .FRAGMENTS_PER_MESSAGE (FRAGMENTS_PER_MESSAGE)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_req_i (emit_req),
    .busy_o     (emit_busy),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .tx_o       (tx_o)
  );

endmodule

FILE: test/mesh_frame_reassembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame reassembler testbench
// Drives received mesh frames into the reassembler byte by byte and checks
// every upstream beat, mostly against a cycle-free model of the frame parser,
// the per-node fragment buffers and the upstream frame builder.
// ----------------------------------------------------------------------------
// The run has two parts. A directed table comes first. Each row is one link
// frame, described by its length byte, node byte, a fill value for the six
// fragment bytes, a bad-check flag and a cut point where the next sync byte
// breaks in. Rows whose outcome is plain from the row itself (a frame that
// sends nothing upstream, or a message of all-zero data) carry their expected upstream beats
// directly. All other rows are checked against the model. The random part
// follows. It is mostly well-formed frames for the four known nodes, so that
// messages complete often, mixed with bad checks, unknown nodes, short
// frames, cut frames and stray noise.
//
// Both channels idle at random. Most gaps are short and a few are long. In
// a recurring window no new gap is drawn on either side. The sender also
// holds off after the directed rows, halfway through the random part and at
// the end until every upstream beat it expects has come back.
// ----------------------------------------------------------------------------
module mesh_frame_reassembler_tb;
  import mfr_pkg::*;

  localparam int unsigned N_NODES       = 4;
  localparam int unsigned FRAG_LEN      = 6;
  localparam int unsigned FRAGS_PER_MSG = 4;
  localparam int unsigned MSG_LEN       = FRAG_LEN * FRAGS_PER_MSG;
  // A frame must reach its check byte to be kept.
  localparam int unsigned MIN_FRAME     = DATA_START + FRAG_LEN + 1;

  localparam int unsigned RANDOM_BYTES  = 150;
  // This wait covers any upstream beat that is still on its way once the
  // last expected one has arrived.
  localparam int unsigned END_WAIT      = 80;
  // The longest quiet stretch is a long gap on one side on top of a
  // long stall on the other.
  localparam int unsigned STUCK_LIMIT   = 4000;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,     // beats come from the model
    CHK_SILENT,    // the frame must cause no upstream beat
    CHK_ZERO_MSG   // the frame completes a message whose data is all zero
  } chk_e;

  typedef struct packed {
    logic [7:0] lead;     // stray bytes sent before the frame
    logic [7:0] len;      // length byte; the frame is len + 4 bytes long
    logic [7:0] node;
    logic [7:0] fill;     // value of every fragment byte
    logic       bad_sum;  // check byte is one off
    logic [8:0] cut;      // number of bytes sent before the next sync; 0 = all
    chk_e       how;
  } frame_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } up_beat_t;

  localparam int N_ROWS = 19;
  localparam frame_row_t DIR_ROWS [N_ROWS] = '{
    // Shortest frame that is kept. Fragment 1 of node 1.
    '{8'd2, 8'd10,  8'd1,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    // Length byte 0. The frame ends on its node byte and is too short.
    '{8'd0, 8'd0,   8'd1,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b1, 9'd0,  CHK_SILENT},
    // One byte short. The check byte is never reached.
    '{8'd0, 8'd9,   8'd1,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd0,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd5,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'hFF,  8'h00, 1'b0, 9'd0,  CHK_SILENT},
    // A sync byte breaks in at the length byte, the node byte, inside the
    // fragment and at the check byte.
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b0, 9'd2,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b0, 9'd3,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b0, 9'd10, CHK_SILENT},
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b0, 9'd13, CHK_SILENT},
    // A longer frame, 44 bytes, whose bytes past the check byte only count
    // toward the length. Fragment 2 of node 1.
    '{8'd0, 8'd40,  8'd1,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd1, 8'd10,  8'd1,   8'h00, 1'b0, 9'd0,  CHK_SILENT},
    // Fragment 4 of node 1 completes a message of 24 zero bytes.
    '{8'd0, 8'd10,  8'd1,   8'h00, 1'b0, 9'd0,  CHK_ZERO_MSG},
    '{8'd0, 8'd10,  8'd4,   8'hFF, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd4,   8'hFF, 1'b1, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd11,  8'd4,   8'hFF, 1'b0, 9'd0,  CHK_SILENT},
    '{8'd0, 8'd10,  8'd4,   8'hFF, 1'b0, 9'd0,  CHK_SILENT},
    // Fourth good fragment of node 4, all 0xFF, in a longer frame.
    '{8'd0, 8'd30,  8'd4,   8'hFF, 1'b0, 9'd0,  CHK_MODEL}
  };

  logic clk_i;
  logic rst_ni;

  mfr_rx_if rx_bus ();
  mfr_tx_if tx_bus ();

  mesh_frame_reassembler #(
    .NODE_COUNT           (N_NODES),
    .FRAGMENT_BYTES       (FRAG_LEN),
    .FRAGMENTS_PER_MESSAGE(FRAGS_PER_MSG)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_bus),
    .tx_o  (tx_bus)
  );

  // Upstream beats still owed by the block, oldest first.
  up_beat_t   upstream_q [$];
  // Beats that the model produced for the byte just taken.
  up_beat_t   emitted_q [$];
  // The link frame that is about to be sent.
  logic [7:0] frame_q [$];

  // Model of the frame parser.
  logic       frm_open;
  logic [8:0] frm_left;
  logic [8:0] frm_len;
  logic [8:0] frm_pos;
  logic [7:0] frm_node;
  logic [7:0] frag [FRAG_LEN];
  logic [7:0] frag_sum;
  logic [7:0] frag_chk;
  // Model of the per-node message buffers.
  logic [7:0] msg_store [N_NODES][MSG_LEN];
  int unsigned msg_fill [N_NODES];

  int unsigned cycle_cnt;
  int unsigned stuck;
  int unsigned tx_hold;
  int unsigned mismatches;
  int unsigned bytes_in;
  int unsigned frames_in;
  int unsigned frames_out;
  int unsigned beats_out;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Most gaps are short and a few are long. In a recurring window every
  // gap is zero, so that the block also sees back-to-back traffic.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt % 700) >= 500) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte except the sync byte, so it cannot break a frame.
  function automatic logic [7:0] fresh_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    return (v == SYNC_BYTE) ? 8'hFF : v;
  endfunction

  // A fragment is complete once the last byte of its frame has been
  // taken. Good fragments go into the buffer of their node, and the
  // fourth one sends the whole message upstream.
  function automatic void close_frame();
    int unsigned idx;
    logic [7:0]  sum;
    frm_open = 1'b0;
    if (frm_len < MIN_FRAME) return;
    if (frag_chk != frag_sum) return;
    if (frm_node < 1 || frm_node > N_NODES) return;
    idx = frm_node - 1;
    if (msg_fill[idx] >= FRAGS_PER_MSG) msg_fill[idx] = 0;
    for (int i = 0; i < FRAG_LEN; i++) begin
      msg_store[idx][msg_fill[idx] * FRAG_LEN + i] = frag[i];
    end
    msg_fill[idx]++;
    if (msg_fill[idx] < FRAGS_PER_MSG) return;
    msg_fill[idx] = 0;
    // The upstream check covers the node byte and all data bytes except
    // the last one.
    sum = frm_node;
    for (int i = 0; i < MSG_LEN - 1; i++) sum += msg_store[idx][i];
    emitted_q.push_back(up_beat_t'{SYNC_BYTE, 1'b0});
    emitted_q.push_back(up_beat_t'{CMD_BYTE, 1'b0});
    emitted_q.push_back(up_beat_t'{SYNC_BYTE, 1'b0});
    emitted_q.push_back(up_beat_t'{AREA_ID, 1'b0});
    emitted_q.push_back(up_beat_t'{frm_node, 1'b0});
    for (int i = 0; i < MSG_LEN; i++) begin
      emitted_q.push_back(up_beat_t'{msg_store[idx][i], 1'b0});
    end
    emitted_q.push_back(up_beat_t'{sum, 1'b0});
    emitted_q.push_back(up_beat_t'{TAIL_BYTE, 1'b1});
  endfunction

  // One received byte through the parser model. A sync byte always opens
  // a new frame. Outside a frame every other byte is ignored.
  function automatic void absorb_rx_byte(input logic [7:0] b);
    logic [8:0] p;
    if (b == SYNC_BYTE) begin
      frm_open = 1'b1;
      frm_pos  = '0;
      frm_len  = '0;
      frm_left = '0;
      frm_node = '0;
      frag_sum = '0;
      frag_chk = '0;
      return;
    end
    if (!frm_open) return;
    p = frm_pos + 9'd1;
    frm_pos = p;
    if (p == 9'd1) return;
    if (p == 9'd2) begin
      frm_len  = {1'b0, b} + 9'd4;
      frm_left = frm_len - 9'd3;
      return;
    end
    if (p == 9'd3) begin
      frm_node = b;
    end else if (p >= DATA_START && p < DATA_START + FRAG_LEN) begin
      frag[p - DATA_START] = b;
      frag_sum += b;
    end else if (p == DATA_START + FRAG_LEN) begin
      frag_chk = b;
    end
    // Bytes after the check byte only count toward the length.
    if (frm_left != 0) frm_left--;
    if (frm_left == 0) close_frame();
  endfunction

  // Lays out a whole link frame, len + 4 bytes long.
  function automatic void build_frame(input logic [7:0] len, input logic [7:0] node,
                                      input logic [7:0] data [FRAG_LEN],
                                      input logic [7:0] chk);
    frame_q.delete();
    for (int p = 0; p < int'(len) + 4; p++) begin
      if (p == 0) frame_q.push_back(SYNC_BYTE);
      else if (p == 2) frame_q.push_back(len);
      else if (p == 3) frame_q.push_back(node);
      else if (p >= DATA_START && p < DATA_START + FRAG_LEN)
        frame_q.push_back(data[p - DATA_START]);
      else if (p == DATA_START + FRAG_LEN) frame_q.push_back(chk);
      else frame_q.push_back(fresh_byte());
    end
  endfunction

  // Offers one beat after a random gap and returns at the edge that takes
  // it. The caller drives the next value in that same step, so valid is
  // never lowered and raised again within one step.
  task automatic put_beat(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
  endtask

  // Sends the first cut bytes of frame_q (all when cut is 0). The model
  // follows every taken byte. Its upstream beats become expectations only
  // when keep is set.
  task automatic send_frame(input int unsigned cut, input bit keep, input bit counted);
    int unsigned n;
    n = (cut != 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      put_beat(frame_q[i]);
      absorb_rx_byte(frame_q[i]);
      if (keep) begin
        foreach (emitted_q[k]) upstream_q.push_back(emitted_q[k]);
      end
      emitted_q.delete();
      if (counted) bytes_in++;
    end
    if (counted) frames_in++;
  endtask

  // The sender holds off until the block has sent everything it owes.
  task automatic drain_upstream();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (upstream_q.size() != 0) @(posedge clk_i);
  endtask

  // Random frames are mostly good ones for the known nodes with short
  // lengths, so that messages complete often. The rest are broken on
  // purpose or are plain noise between frames.
  task automatic random_frame();
    logic [7:0]  data [FRAG_LEN];
    logic [7:0]  len;
    logic [7:0]  node;
    logic [7:0]  sum;
    int unsigned r;
    int unsigned cut;
    r    = $urandom_range(0, 99);
    cut  = 0;
    len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(10, 255))
                                        : 8'($urandom_range(10, 13));
    if (len == SYNC_BYTE) len = 8'hFD;
    node = 8'($urandom_range(1, N_NODES));
    sum  = '0;
    foreach (data[i]) begin
      data[i] = fresh_byte();
      sum += data[i];
    end
    // A check byte of 0xFE would restart the frame, so a good frame
    // keeps its sum away from it.
    if (sum == SYNC_BYTE) begin
      sum     = sum - data[0];
      data[0] = (data[0] == 8'hFD) ? 8'h00 : data[0] + 8'd1;
      sum     = sum + data[0];
    end
    if (r >= 97) begin
      frame_q.delete();
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      send_frame(0, 1'b1, 1'b0);
      return;
    end
    if (r >= 90) cut = $urandom_range(1, int'(len) + 3);
    else if (r >= 84) len = 8'($urandom_range(0, MIN_FRAME - 5));
    else if (r >= 78)
      node = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(N_NODES + 1, 255));
    else if (r >= 70) sum = sum + 8'($urandom_range(1, 255));
    build_frame(len, node, data, sum);
    send_frame(cut, 1'b1, 1'b1);
  endtask

  // The receiver stalls at random as well.
  always @(posedge clk_i) begin
    if (tx_hold != 0) begin
      tx_bus.ready <= 1'b0;
      tx_hold      <= tx_hold - 1;
    end else begin
      tx_bus.ready <= 1'b1;
      tx_hold      <= pick_gap();
    end
  end

  // Every upstream beat is checked against the oldest expectation.
  always @(posedge clk_i) begin : upstream_check
    up_beat_t want;
    if (rst_ni && tx_bus.valid && tx_bus.ready) begin
      beats_out++;
      if (upstream_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected upstream beat, expected none, actual %02h last %0b",
                 $time, tx_bus.tx_byte, tx_bus.tx_last);
      end else begin
        want = upstream_q.pop_front();
        if (tx_bus.tx_byte !== want.data) begin
          mismatches++;
          $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                   $time, want.data, tx_bus.tx_byte);
        end
        if (tx_bus.tx_last !== want.last) begin
          mismatches++;
          $display("%0t: tx_last mismatch, expected %0b, actual %0b",
                   $time, want.last, tx_bus.tx_last);
        end
      end
      if (tx_bus.tx_last === 1'b1) frames_out++;
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready)) begin
        stuck <= 0;
      end else if (stuck < STUCK_LIMIT) begin
        stuck <= stuck + 1;
      end else begin
        $display("%0t: no beat for %0d cycles, %0d upstream beats still owed",
                 $time, STUCK_LIMIT, upstream_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    frame_row_t  row;
    logic [7:0]  data [FRAG_LEN];
    logic [7:0]  sum;
    logic [7:0]  zero_head [HEAD_LEN];
    int unsigned rand_start;
    bit          paused;

    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    tx_bus.ready   = 1'b0;
    cycle_cnt      = 0;
    stuck          = 0;
    tx_hold        = 0;
    mismatches     = 0;
    bytes_in       = 0;
    frames_in      = 0;
    frames_out     = 0;
    beats_out      = 0;
    paused         = 1'b0;

    // The model starts from the reset state of the block.
    frm_open = 1'b0;
    frm_left = '0;
    frm_len  = '0;
    frm_pos  = '0;
    frm_node = '0;
    frag_sum = '0;
    frag_chk = '0;
    foreach (msg_fill[i]) msg_fill[i] = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows.
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIR_ROWS[r];
      sum = '0;
      foreach (data[i]) begin
        data[i] = row.fill;
        sum += row.fill;
      end
      build_frame(row.len, row.node, data, sum + 8'(row.bad_sum));
      for (int k = 0; k < int'(row.lead); k++) frame_q.push_front((k % 2) ? 8'hFF : 8'h00);
      send_frame(row.cut, row.how == CHK_MODEL, 1'b1);
      if (row.how == CHK_ZERO_MSG) begin
        // Header, 24 zero bytes, a check that is just the node byte, tail.
        zero_head = '{SYNC_BYTE, CMD_BYTE, SYNC_BYTE, AREA_ID, row.node};
        foreach (zero_head[k]) upstream_q.push_back(up_beat_t'{zero_head[k], 1'b0});
        repeat (MSG_LEN) upstream_q.push_back(up_beat_t'{8'h00, 1'b0});
        upstream_q.push_back(up_beat_t'{row.node, 1'b0});
        upstream_q.push_back(up_beat_t'{TAIL_BYTE, 1'b1});
      end
    end
    drain_upstream();

    // Random frames. Halfway through, the sender waits once more until the
    // block has caught up.
    rand_start = bytes_in;
    while (bytes_in - rand_start < RANDOM_BYTES) begin
      if (!paused && bytes_in - rand_start >= RANDOM_BYTES / 2) begin
        drain_upstream();
        paused = 1'b1;
      end
      random_frame();
    end

    drain_upstream();
    repeat (END_WAIT) @(posedge clk_i);

    $display("Sent %0d frames (%0d bytes, stray noise not counted), %0d directed rows first.",
             frames_in, bytes_in, N_ROWS);
    $display("Checked %0d upstream beats in %0d upstream frames, %0d mismatches.",
             beats_out, frames_out, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
